@@ rtl/assert_macros.svh @@
// Assertion macros for the divider RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/hfd_pkg.sv @@
// Types and constants for the half-precision divider.
// Depends on nothing; used by every module of the block.
package hfd_pkg;
  localparam int unsigned MantW = 11;
  localparam int unsigned RemW = 14;
  localparam int unsigned Steps = 21;
  localparam int unsigned Stages = 7;
  localparam int unsigned StepsPerStage = 3;
  localparam logic [9:0] FracMask = 10'h3ff;
  localparam logic [14:0] MagMax = 15'h7fff;
  localparam logic [4:0] ExpAllOnes = 5'h1f;
  localparam int signed Bias = 15;
  localparam int signed ExpMax = 30;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_SAT    = 2'd1,
    KIND_ZERO   = 2'd2
  } kind_t;

  // Item state carried along the SRT pipeline.
  typedef struct packed {
    logic              sign;
    kind_t             kind;
    logic signed [7:0] exp;
    logic [MantW-1:0]  dvs;
    logic signed [RemW-1:0] rem;
    logic [Steps-1:0]  qpos;
    logic [Steps-1:0]  qneg;
  } work_t;
endpackage

@@ rtl/hfd_srt_stage.sv @@
// One pipeline stage of the radix-2 SRT recurrence: three steps per stage.
// Depends on hfd_pkg.
module hfd_srt_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  hfd_pkg::work_t in_work,
  output logic           out_valid,
  output hfd_pkg::work_t out_work
);
  hfd_pkg::work_t step_work;

  // The remainder counts in half units against a doubled divisor, so it stays
  // in [-2*dvs, 2*dvs) and the digit thresholds sit at plus and minus 2048.
  always_comb begin
    logic signed [hfd_pkg::RemW-1:0] r2;
    logic signed [hfd_pkg::RemW-1:0] dv;
    step_work = in_work;
    dv = $signed({2'b00, in_work.dvs, 1'b0});
    for (int i = 0; i < hfd_pkg::StepsPerStage; i++) begin
      r2 = step_work.rem <<< 1;
      step_work.qpos = step_work.qpos << 1;
      step_work.qneg = step_work.qneg << 1;
      if (r2 >= $signed(14'sd2048)) begin
        step_work.rem = r2 - dv;
        step_work.qpos[0] = 1'b1;
      end else if (r2 < $signed(-14'sd2048)) begin
        step_work.rem = r2 + dv;
        step_work.qneg[0] = 1'b1;
      end else begin
        step_work.rem = r2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_work <= step_work;
    end
  end
endmodule

@@ rtl/half_float_divider_core.sv @@
// Top level of the half-precision divider: unpack, SRT pipeline, normalize.
// Depends on hfd_pkg, hfd_srt_stage and assert_macros.svh.
//
// Usage: s_axis carries one word per division, dividend in tdata[15:0]
// and divisor in tdata[31:16]. m_axis returns the 16-bit quotient pattern.
// The quotient passes on to m_axis through one unpack register, seven SRT
// stages of three steps each, and one normalize and output register,
// nine registers in all, whenever the output is not stalled.
// One word is accepted per cycle when the output is taken or empty;
// throughput is then one division per cycle.
// The whole pipeline advances together, so when the receiver holds
// m_axis_tready low with a result waiting, s_axis_tready falls and every
// stage holds; nothing is lost or repeated. An empty output slot lets the
// pipeline keep moving regardless of m_axis_tready.
// Reset clears all valid bits; no word is in flight afterwards.
// Subnormal inputs are read with the hidden bit set; no rounding is done.
`include "assert_macros.svh"
module half_float_divider_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] dividend, [31:16] divisor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] quotient
);
  localparam int unsigned NS = hfd_pkg::Stages;

  logic           en;
  logic           v0;
  hfd_pkg::work_t w0;
  logic           sv [NS+1];
  hfd_pkg::work_t sw [NS+1];
  hfd_pkg::work_t u_work;
  logic [15:0]    q_next;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    logic [15:0] x;
    logic [15:0] d;
    x = s_axis_tdata[15:0];
    d = s_axis_tdata[31:16];
    u_work.sign = x[15] ^ d[15];
    if (d[14:0] == 15'd0 || x[14:10] == hfd_pkg::ExpAllOnes ||
        d[14:10] == hfd_pkg::ExpAllOnes) begin
      u_work.kind = hfd_pkg::KIND_SAT;
    end else if (x[14:0] == 15'd0) begin
      u_work.kind = hfd_pkg::KIND_ZERO;
    end else begin
      u_work.kind = hfd_pkg::KIND_NORMAL;
    end
    u_work.exp = $signed({3'b000, x[14:10]}) - $signed({3'b000, d[14:10]})
                 + 8'sd15;
    u_work.dvs = {1'b1, d[9:0]};
    // In half units the full mantissa is one half of the dividend, which
    // keeps the first SRT step in range.
    u_work.rem = $signed({3'b000, 1'b1, x[9:0]});
    u_work.qpos = '0;
    u_work.qneg = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w0 <= u_work;
    end
  end

  assign sv[0] = v0;
  assign sw[0] = w0;

  for (genvar g = 0; g < NS; g++) begin : g_srt
    hfd_srt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[g]),
      .in_work   (sw[g]),
      .out_valid (sv[g+1]),
      .out_work  (sw[g+1])
    );
  end

  // After repair, qpos - qneg over 21 digits is floor(mx * 2^20 / md), so its
  // top 11 bits are floor(mx * 1024 / md).
  always_comb begin
    hfd_pkg::work_t wf;
    logic [hfd_pkg::Steps:0] qraw;
    logic [11:0] q;
    logic signed [7:0] e;
    wf = sw[NS];
    qraw = {1'b0, wf.qpos} - {1'b0, wf.qneg};
    if (wf.rem < 0) begin
      qraw = qraw - 1'b1;
    end
    q = {1'b0, qraw[20:10]};
    e = wf.exp;
    if (!q[10]) begin
      q = q << 1;
      e = e - 8'sd1;
    end
    case (wf.kind)
      hfd_pkg::KIND_SAT:  q_next = {wf.sign, hfd_pkg::MagMax};
      hfd_pkg::KIND_ZERO: q_next = 16'h0000;
      default: begin
        if (e > 8'sd30) begin
          q_next = {wf.sign, hfd_pkg::MagMax};
        end else if (e < 8'sd1) begin
          q_next = 16'h0000;
        end else begin
          q_next = {wf.sign, e[4:0], q[9:0] & hfd_pkg::FracMask};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= q_next;
    end
  end

  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)
  `ASSERT_NEXT(a_hold_on_stall, clk, rst, m_axis_tvalid && !m_axis_tready, sv[NS] == $past(sv[NS]))
  `ASSERT_NEXT(a_advance, clk, rst, en && sv[NS], m_axis_tvalid)
endmodule
